>>> sv/assert_macros.svh
// Assertion helpers used by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MZ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> sv/mz_pkg.sv
`default_nettype none

package mz_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 65536;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned WIDE_W        = 64;
  localparam int unsigned NUM_LANES     = 3;
  localparam int unsigned CORR_STEPS    = 41;
  localparam int unsigned AVG_STEPS     = WIDE_W;
  localparam int unsigned STEP_W        = $clog2(AVG_STEPS);
  localparam int unsigned REM_PAD       = WIDE_W - CORR_STEPS;

  localparam logic [CORR_STEPS-1:0] Q_CLAMP = {1'b1, {(CORR_STEPS-1){1'b0}}};

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ACC   = 2'd1;
  localparam logic [1:0] ACT_CORR  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_MASS = 2'd1;
  localparam logic [1:0] ST_NO_COUNT  = 2'd2;
  localparam logic [1:0] ST_SAT       = 2'd3;

  typedef struct packed {
    logic load;
    logic clear;
    logic mul;
    logic acc;
    logic avg_zero;
    logic avg_load;
    logic avg_store;
    logic corr_load;
    logic step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       counted;
    logic       mass_zero;
    logic       count_zero;
    logic       avg_ready;
    logic       out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> sv/mz_if.sv
`default_nettype none

interface mz_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         action;
  logic                               counted;
  logic [mz_pkg::DATA_W-1:0]          mass;
  logic signed [mz_pkg::DATA_W-1:0]   vel_x;
  logic signed [mz_pkg::DATA_W-1:0]   vel_y;
  logic signed [mz_pkg::DATA_W-1:0]   vel_z;

  modport source (output valid, action, counted, mass, vel_x, vel_y, vel_z, input ready);
  modport sink   (input valid, action, counted, mass, vel_x, vel_y, vel_z, output ready);
endinterface

interface mz_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mz_pkg::DATA_W-1:0]   new_vel_x;
  logic signed [mz_pkg::DATA_W-1:0]   new_vel_y;
  logic signed [mz_pkg::DATA_W-1:0]   new_vel_z;
  logic [1:0]                         status;

  modport source (output valid, new_vel_x, new_vel_y, new_vel_z, status, input ready);
  modport sink   (input valid, new_vel_x, new_vel_y, new_vel_z, status, output ready);
endinterface

`default_nettype wire

>>> sv/mz_div.sv
`default_nettype none

// Radix-2 restoring divider, one quotient bit per step.
module mz_div (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  logic [mz_pkg::DATA_W-1:0]   rem_init,
  input  logic [mz_pkg::WIDE_W-1:0]   dvd_init,
  input  logic [mz_pkg::DATA_W-1:0]   divisor,
  output logic [mz_pkg::WIDE_W-1:0]   quo
);

  logic [mz_pkg::DATA_W-1:0] rem_r;
  logic [mz_pkg::WIDE_W-1:0] dvd_r;
  logic [mz_pkg::DATA_W-1:0] div_r;
  logic [mz_pkg::DATA_W:0]   rem_sh;
  logic [mz_pkg::DATA_W:0]   rem_sub;
  logic                      q_bit;
  logic [mz_pkg::DATA_W-1:0] rem_nxt;

  assign rem_sh  = {rem_r, dvd_r[mz_pkg::WIDE_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign q_bit   = !rem_sub[mz_pkg::DATA_W];
  assign rem_nxt = q_bit ? rem_sub[mz_pkg::DATA_W-1:0] : rem_sh[mz_pkg::DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= rem_init;
      dvd_r <= dvd_init;
      div_r <= divisor;
    end else if (step) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[mz_pkg::WIDE_W-2:0], q_bit};
    end
  end

  assign quo = dvd_r;

endmodule

`default_nettype wire

>>> sv/mz_datapath.sv
`default_nettype none

module mz_datapath #(
  parameter int unsigned MAX_ITEMS = mz_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mz_pkg::dp_cmd_t                   cmd,
  output mz_pkg::dp_sts_t                   sts,
  input  logic [1:0]                        in_action,
  input  logic                              in_counted,
  input  logic [mz_pkg::DATA_W-1:0]         in_mass,
  input  logic signed [mz_pkg::DATA_W-1:0]  in_vel_x,
  input  logic signed [mz_pkg::DATA_W-1:0]  in_vel_y,
  input  logic signed [mz_pkg::DATA_W-1:0]  in_vel_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mz_pkg::DATA_W-1:0]  out_new_vel_x,
  output logic signed [mz_pkg::DATA_W-1:0]  out_new_vel_y,
  output logic signed [mz_pkg::DATA_W-1:0]  out_new_vel_z,
  output logic [1:0]                        out_status
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned NL = mz_pkg::NUM_LANES;
  localparam int unsigned DW = mz_pkg::DATA_W;
  localparam int unsigned WW = mz_pkg::WIDE_W;
  localparam int unsigned QW = mz_pkg::CORR_STEPS;
  localparam int unsigned RW = QW + 2;

  localparam logic [WW-1:0] S64_MAX = {1'b0, {(WW-1){1'b1}}};
  localparam logic [WW-1:0] S64_MIN = {1'b1, {(WW-1){1'b0}}};
  localparam logic [DW-1:0] S32_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] S32_MIN = {1'b1, {(DW-1){1'b0}}};

  // Captured item
  logic [1:0]     action_r;
  logic           counted_r;
  logic [DW-1:0]  mass_r;
  logic [DW-1:0]  vel_r [NL];

  // Pass state
  logic [WW-1:0]  sum_r [NL];
  logic [WW-1:0]  avg_r [NL];
  logic [WW-1:0]  prod_r [NL];
  logic [CW-1:0]  count_r;
  logic           avg_ready_r;
  logic           sum_sat_r;
  logic [NL-1:0]  ovf_r;

  // Output register
  logic           out_valid_r;
  logic [DW-1:0]  out_vel_r [NL];
  logic [1:0]     out_status_r;

  // Lane signals
  logic [WW-1:0]  mag_sum [NL];
  logic [WW-1:0]  mag_avg [NL];
  logic [WW-1:0]  prod_nxt [NL];
  logic [WW-1:0]  sum_nxt [NL];
  logic [WW-1:0]  quo [NL];
  logic [WW-1:0]  dvd_init [NL];
  logic [DW-1:0]  rem_init [NL];
  logic [DW-1:0]  divisor [NL];
  logic [DW-1:0]  corr_vel [NL];
  logic [DW-1:0]  res_vel [NL];
  logic [NL-1:0]  add_ovf;
  logic [NL-1:0]  ovf_nxt;
  logic [NL-1:0]  out_clamp;
  logic [1:0]     res_status;
  logic           count_full;
  logic           mass_zero;
  logic           count_zero;

  assign mass_zero  = (mass_r == '0);
  assign count_zero = (count_r == '0);
  assign count_full = (count_r >= CW'(MAX_ITEMS));

  for (genvar i = 0; i < NL; i++) begin : g_lane
    logic signed [WW:0]   prod_full;
    logic [WW:0]          sum_ext;
    logic [QW-1:0]        q_lim;
    logic [RW-1:0]        d_mag;
    logic [RW-1:0]        d_sgn;
    logic [RW-1:0]        r_val;
    logic                 r_fits;

    assign mag_sum[i] = sum_r[i][WW-1] ? (~sum_r[i] + 1'b1) : sum_r[i];
    assign mag_avg[i] = avg_r[i][WW-1] ? (~avg_r[i] + 1'b1) : avg_r[i];

    // Unsigned mass times signed velocity fits exactly in 64 bits
    assign prod_full   = $signed({1'b0, mass_r}) * $signed(vel_r[i]);
    assign prod_nxt[i] = prod_full[WW-1:0];

    assign sum_ext    = {sum_r[i][WW-1], sum_r[i]} + {prod_r[i][WW-1], prod_r[i]};
    assign add_ovf[i] = sum_ext[WW] != sum_ext[WW-1];
    assign sum_nxt[i] = add_ovf[i] ? (sum_ext[WW] ? S64_MIN : S64_MAX) : sum_ext[WW-1:0];

    // Quotient of 2^41 or more is caught up front and clamped
    assign ovf_nxt[i]  = DW'(mag_avg[i][WW-1:QW]) >= mass_r;
    assign dvd_init[i] = cmd.avg_load ? mag_sum[i] : {mag_avg[i][QW-1:0], {mz_pkg::REM_PAD{1'b0}}};
    assign rem_init[i] = cmd.avg_load ? '0 : DW'(mag_avg[i][WW-1:QW]);
    assign divisor[i]  = cmd.avg_load ? DW'(count_r) : mass_r;

    mz_div u_div (
      .clk      (clk),
      .load     (cmd.avg_load | cmd.corr_load),
      .step     (cmd.step),
      .rem_init (rem_init[i]),
      .dvd_init (dvd_init[i]),
      .divisor  (divisor[i]),
      .quo      (quo[i])
    );

    assign q_lim = (ovf_r[i] || (quo[i][QW-1:0] > mz_pkg::Q_CLAMP)) ?
                   mz_pkg::Q_CLAMP : quo[i][QW-1:0];
    assign d_mag = {2'b00, q_lim};
    assign d_sgn = avg_r[i][WW-1] ? (~d_mag + 1'b1) : d_mag;
    assign r_val = {{(RW-DW){vel_r[i][DW-1]}}, vel_r[i]} - d_sgn;
    assign r_fits = (r_val[RW-1:DW-1] == '0) || (r_val[RW-1:DW-1] == '1);
    assign out_clamp[i] = !r_fits;
    assign corr_vel[i]  = r_fits ? r_val[DW-1:0] : (r_val[RW-1] ? S32_MIN : S32_MAX);
  end

  always_comb begin
    res_status = mz_pkg::ST_OK;
    for (int i = 0; i < NL; i++) begin
      res_vel[i] = vel_r[i];
    end
    if (!counted_r) begin
      res_status = mz_pkg::ST_OK;
    end else if (mass_zero) begin
      res_status = mz_pkg::ST_ZERO_MASS;
    end else if (count_zero) begin
      res_status = mz_pkg::ST_NO_COUNT;
    end else begin
      for (int i = 0; i < NL; i++) begin
        res_vel[i] = corr_vel[i];
      end
      res_status = (sum_sat_r || (|out_clamp)) ? mz_pkg::ST_SAT : mz_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NL; i++) begin
        sum_r[i] <= '0;
        avg_r[i] <= '0;
      end
      count_r     <= '0;
      avg_ready_r <= 1'b0;
      sum_sat_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        for (int i = 0; i < NL; i++) begin
          sum_r[i] <= '0;
          avg_r[i] <= '0;
        end
        count_r     <= '0;
        avg_ready_r <= 1'b0;
        sum_sat_r   <= 1'b0;
      end
      if (cmd.acc) begin
        for (int i = 0; i < NL; i++) begin
          sum_r[i] <= sum_nxt[i];
        end
        if (!count_full) begin
          count_r <= count_r + 1'b1;
        end
        sum_sat_r <= sum_sat_r | (|add_ovf) | count_full;
      end
      if (cmd.avg_zero) begin
        for (int i = 0; i < NL; i++) begin
          avg_r[i] <= '0;
        end
        avg_ready_r <= 1'b1;
      end
      if (cmd.avg_store) begin
        for (int i = 0; i < NL; i++) begin
          avg_r[i] <= sum_r[i][WW-1] ? (~quo[i] + 1'b1) : quo[i];
        end
        avg_ready_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r  <= in_action;
      counted_r <= in_counted;
      mass_r    <= in_mass;
      vel_r[0]  <= in_vel_x;
      vel_r[1]  <= in_vel_y;
      vel_r[2]  <= in_vel_z;
    end
    if (cmd.mul) begin
      for (int i = 0; i < NL; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
    end
    if (cmd.corr_load) begin
      ovf_r <= ovf_nxt;
    end
    if (cmd.emit) begin
      for (int i = 0; i < NL; i++) begin
        out_vel_r[i] <= res_vel[i];
      end
      out_status_r <= res_status;
    end
  end

  assign sts.action     = action_r;
  assign sts.counted    = counted_r;
  assign sts.mass_zero  = mass_zero;
  assign sts.count_zero = count_zero;
  assign sts.avg_ready  = avg_ready_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_new_vel_x = out_vel_r[0];
  assign out_new_vel_y = out_vel_r[1];
  assign out_new_vel_z = out_vel_r[2];
  assign out_status    = out_status_r;

endmodule

`default_nettype wire

>>> sv/mz_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module mz_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mz_pkg::dp_sts_t  sts,
  output mz_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_ADD,
    S_AVG,
    S_AVG_DONE,
    S_CHECK,
    S_CORR,
    S_FIN
  } state_t;

  state_t                    state_r, state_nxt;
  logic [mz_pkg::STEP_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.action)
          mz_pkg::ACT_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end
          mz_pkg::ACT_ACC: begin
            state_nxt = sts.counted ? S_MUL : S_IDLE;
          end
          mz_pkg::ACT_CORR: begin
            if (sts.avg_ready) begin
              state_nxt = S_CHECK;
            end else if (sts.count_zero) begin
              cmd.avg_zero = 1'b1;
              state_nxt    = S_CHECK;
            end else begin
              cmd.avg_load = 1'b1;
              cnt_nxt      = mz_pkg::STEP_W'(mz_pkg::AVG_STEPS - 1);
              state_nxt    = S_AVG;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.acc   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_AVG: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_AVG_DONE;
        end
      end
      S_AVG_DONE: begin
        cmd.avg_store = 1'b1;
        state_nxt     = S_CHECK;
      end
      S_CHECK: begin
        if (sts.counted && !sts.mass_zero && !sts.count_zero) begin
          cmd.corr_load = 1'b1;
          cnt_nxt       = mz_pkg::STEP_W'(mz_pkg::CORR_STEPS - 1);
          state_nxt     = S_CORR;
        end else if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CORR: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // A pending result is never overwritten
  `MZ_ASSERT_SAME(a_emit_free, clk, rst_n, cmd.emit, sts.out_free)
  // Division by mass only runs with a nonzero mass and count
  `MZ_ASSERT_SAME(a_corr_ok, clk, rst_n, cmd.corr_load, sts.counted && !sts.mass_zero && !sts.count_zero)
  // The average is marked fixed right after it is written
  `MZ_ASSERT_NEXT(a_avg_fixed, clk, rst_n, cmd.avg_store || cmd.avg_zero, sts.avg_ready)

endmodule

`default_nettype wire

>>> sv/momentum_zeroing.sv
// Flow: one item at a time; a new item is taken only in idle. Clear, an uncounted accumulate
//   or an unused action ends after decode; a counted accumulate also multiplies and adds.
//   The first correction after a clear runs the 64-step average by count when the pass has
//   counted items. A correction for an uncounted item, a zero mass or an empty count is then
//   emitted from the check; a corrected item first runs the 41-step radix-2 division by mass.
// Reset: synchronous, active low; clears sums, count, averages, ready and saturation flags and output valid.
`default_nettype none

module momentum_zeroing #(
  parameter int unsigned MAX_ITEMS = mz_pkg::MAX_ITEMS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  mz_in_if.sink    in_chan,
  mz_out_if.source out_chan
);

  // Command and status between the sequencer and the three-lane datapath
  mz_pkg::dp_cmd_t cmd;
  mz_pkg::dp_sts_t sts;

  // Sequencer: takes one item, steps the dividers that average and correction share, hands the result off
  mz_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: sums, averages, one divider lane per axis and the output register.
  // The output register lets the next item start while a result waits.
  mz_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_chan.action),
    .in_counted    (in_chan.counted),
    .in_mass       (in_chan.mass),
    .in_vel_x      (in_chan.vel_x),
    .in_vel_y      (in_chan.vel_y),
    .in_vel_z      (in_chan.vel_z),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_new_vel_x (out_chan.new_vel_x),
    .out_new_vel_y (out_chan.new_vel_y),
    .out_new_vel_z (out_chan.new_vel_z),
    .out_status    (out_chan.status)
  );

endmodule

`default_nettype wire
